/* rtl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is held low.
`define ECH_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ech check failed");

// Clocked check that also runs through reset.
`define ECH_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ech reset check failed");

`endif

/* rtl/ech_pkg.sv */
// ----------------------------------------------------------------------------
// ech_pkg
// Types, codes and constants of the engage controller with hysteresis.
// ----------------------------------------------------------------------------
`default_nettype none

package ech_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int FULL_SCALE  = (1 << SAMPLE_BITS) - 1;
    localparam int CMP_W       = ((SAMPLE_BITS > 12) ? SAMPLE_BITS : 12) + 1;

    // command bytes
    localparam logic [7:0] CMD_ENGAGE    = 8'h31;
    localparam logic [7:0] CMD_DISENGAGE = 8'h30;
    localparam logic [7:0] CMD_AUTO      = 8'h41;

    localparam logic [7:0]  ANGLE_MAX  = 8'd180;
    localparam logic [11:0] PULSE_BASE = 12'd600;

    // configuration map
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_BAND      = 2'd1;
    localparam logic [1:0] REG_LOCKOUT   = 2'd2;
    localparam logic [1:0] REG_PERIOD    = 2'd3;

    localparam logic [11:0] RST_THRESHOLD = 12'd2048;
    localparam logic [11:0] RST_BAND      = 12'd200;
    localparam logic [15:0] RST_LOCKOUT   = 16'd300;
    localparam logic [15:0] RST_PERIOD    = 16'd200;

    typedef struct packed {
        logic [31:0]            time_ms;
        logic                   cmd_valid;
        logic [7:0]             cmd_byte;
        logic                   ir_level;
        logic                   btn_level;
        logic [SAMPLE_BITS-1:0] pot_sample;
    } t_ech_in;

    typedef struct packed {
        logic                   engaged_now;
        logic                   auto_on;
        logic [7:0]             angle_deg;
        logic [11:0]            servo_pulse_us;
        logic                   led_standby;
        logic                   led_active;
        logic [SAMPLE_BITS-1:0] pot_echo;
        logic                   report_due;
    } t_ech_out;

    typedef struct packed {
        logic [11:0] center_level;
        logic [11:0] hysteresis_band;
        logic [15:0] toggle_lockout_ms;
        logic [15:0] report_period_ms;
    } t_ech_cfg;

    typedef struct packed {
        logic        engaged;
        logic        auto_en;
        logic [31:0] toggle_stamp;
        logic [31:0] report_stamp;
        logic        prev_ir;
        logic        prev_btn;
    } t_ech_state;

endpackage

`default_nettype wire

/* rtl/ech_apb_regs.sv */
// ----------------------------------------------------------------------------
// ech_apb_regs
// APB register file holding the four controller settings.
// ----------------------------------------------------------------------------
`default_nettype none

module ech_apb_regs (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [ech_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ech_pkg::DATA_W-1:0] pwdata,
    output logic      [ech_pkg::DATA_W-1:0] prdata,
    output logic                           pready,
    output ech_pkg::t_ech_cfg              o_cfg
);
    import ech_pkg::*;

    t_ech_cfg   r_cfg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_level      <= RST_THRESHOLD;
            r_cfg.hysteresis_band   <= RST_BAND;
            r_cfg.toggle_lockout_ms <= RST_LOCKOUT;
            r_cfg.report_period_ms  <= RST_PERIOD;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_THRESHOLD: r_cfg.center_level      <= pwdata[11:0];
                REG_BAND:      r_cfg.hysteresis_band   <= pwdata[11:0];
                REG_LOCKOUT:   r_cfg.toggle_lockout_ms <= pwdata[15:0];
                REG_PERIOD:    r_cfg.report_period_ms  <= pwdata[15:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_THRESHOLD: prdata = {20'd0, r_cfg.center_level};
            REG_BAND:      prdata = {20'd0, r_cfg.hysteresis_band};
            REG_LOCKOUT:   prdata = {16'd0, r_cfg.toggle_lockout_ms};
            REG_PERIOD:    prdata = {16'd0, r_cfg.report_period_ms};
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/ech_step.sv */
// ----------------------------------------------------------------------------
// ech_step
// One control pass: command, local toggle, auto band, servo map, report.
// ----------------------------------------------------------------------------
`default_nettype none

module ech_step (
    input  ech_pkg::t_ech_cfg   i_cfg,
    input  ech_pkg::t_ech_state i_state,
    input  ech_pkg::t_ech_in    i_item,
    output ech_pkg::t_ech_state o_state,
    output ech_pkg::t_ech_out   o_result
);
    import ech_pkg::*;

    logic                     cmd_eng, cmd_dis, cmd_auto;
    logic                     eng_c, auto_c;
    logic [31:0]              stamp_c;
    logic                     rise;
    logic [31:0]              dt_toggle;
    logic                     do_toggle;
    logic                     eng_t, auto_t;
    logic [CMP_W-1:0]         pot_x, thr_x, band_x;
    logic                     above_hi, below_lo;
    logic                     eng_f;
    logic [SAMPLE_BITS+7:0]   prod;
    logic [7:0]               quo;
    logic [SAMPLE_BITS:0]     rem;
    logic [7:0]               quo_fix;
    logic [7:0]               angle;
    logic [31:0]              dt_report;
    logic                     report;

    // command byte
    assign cmd_eng  = i_item.cmd_valid && (i_item.cmd_byte == CMD_ENGAGE);
    assign cmd_dis  = i_item.cmd_valid && (i_item.cmd_byte == CMD_DISENGAGE);
    assign cmd_auto = i_item.cmd_valid && (i_item.cmd_byte == CMD_AUTO);

    always_comb begin
        eng_c   = i_state.engaged;
        auto_c  = i_state.auto_en;
        stamp_c = i_state.toggle_stamp;
        priority if (cmd_eng || cmd_dis) begin
            eng_c   = cmd_eng;
            auto_c  = 1'b0;
            stamp_c = i_item.time_ms;
        end else if (cmd_auto) begin
            auto_c  = 1'b1;
        end else begin
            // no command: state holds
        end
    end

    // local toggle, lockout measured with wrapping difference
    assign rise = (i_item.ir_level && !i_state.prev_ir) ||
                  (i_item.btn_level && !i_state.prev_btn);
    assign dt_toggle = i_item.time_ms - stamp_c;
    assign do_toggle = rise && (dt_toggle > {16'd0, i_cfg.toggle_lockout_ms});
    assign eng_t     = do_toggle ? !eng_c : eng_c;
    assign auto_t    = do_toggle ? 1'b0   : auto_c;

    // auto band; pot + band < thr is the signed lower compare without a sign bit
    assign pot_x    = CMP_W'(i_item.pot_sample);
    assign thr_x    = CMP_W'(i_cfg.center_level);
    assign band_x   = CMP_W'(i_cfg.hysteresis_band);
    assign above_hi = pot_x > (thr_x + band_x);
    assign below_lo = (pot_x + band_x) < thr_x;

    always_comb begin
        eng_f = eng_t;
        if (auto_t) begin
            priority if (above_hi) eng_f = 1'b1;
            else if (below_lo)     eng_f = 1'b0;
            else                   eng_f = eng_t;
        end
    end

    // angle = pot*180 / (2^S-1): quotient by 2^S, then one correction step
    assign prod    = (SAMPLE_BITS+8)'(i_item.pot_sample) * (SAMPLE_BITS+8)'(ANGLE_MAX);
    assign quo     = prod[SAMPLE_BITS+7:SAMPLE_BITS];
    assign rem     = (SAMPLE_BITS+1)'(quo) + {1'b0, prod[SAMPLE_BITS-1:0]};
    assign quo_fix = (rem >= (SAMPLE_BITS+1)'(FULL_SCALE)) ? quo + 8'd1 : quo;
    assign angle   = !eng_f ? 8'd0 :
                     (quo_fix > ANGLE_MAX) ? ANGLE_MAX : quo_fix;

    // report period
    assign dt_report = i_item.time_ms - i_state.report_stamp;
    assign report    = dt_report >= {16'd0, i_cfg.report_period_ms};

    always_comb begin
        o_state.engaged      = eng_f;
        o_state.auto_en      = auto_t;
        o_state.toggle_stamp = do_toggle ? i_item.time_ms : stamp_c;
        o_state.report_stamp = report ? i_item.time_ms : i_state.report_stamp;
        o_state.prev_ir      = i_item.ir_level;
        o_state.prev_btn     = i_item.btn_level;

        o_result.engaged_now    = eng_f;
        o_result.auto_on        = auto_t;
        o_result.angle_deg      = angle;
        o_result.servo_pulse_us = PULSE_BASE + {1'b0, angle, 3'd0} + {3'd0, angle, 1'b0};
        o_result.led_standby    = !eng_f;
        o_result.led_active     = eng_f;
        o_result.pot_echo       = i_item.pot_sample;
        o_result.report_due     = report;
    end

endmodule

`default_nettype wire

/* rtl/engage_controller_with_hysteresis_unit.sv */
// ----------------------------------------------------------------------------
// engage_controller_with_hysteresis_unit
// Engage flag controller: commands, debounced local toggle, auto hysteresis
// band, pot-to-servo mapping and a periodic report flag.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  -------   ---------  ----------------------  -------------------------
//  in        sink       i_in_valid/o_in_ready   i_in_data  (t_ech_in)
//  out       source     o_out_valid/i_out_ready o_out_data (t_ech_out)
//  cfg       APB slave  psel/penable, pready=1  paddr/pwdata/prdata
//
//  An input beat passes through the input register, then the
//  single-pass update into the result register.
//  One beat per clock while the result side is ready; controller state is
//  updated as an item moves from the input register to the result register.
//  A stalled result holds the input register; the input side keeps taking
//  beats while the result register is being drained in the same cycle.
//  Synchronous active-low reset clears valids, resets state and settings.
// ----------------------------------------------------------------------------
`default_nettype none

module engage_controller_with_hysteresis_unit (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // input item channel
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  ech_pkg::t_ech_in               i_in_data,
    // result channel
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output ech_pkg::t_ech_out              o_out_data,
    // configuration
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [ech_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ech_pkg::DATA_W-1:0] pwdata,
    output logic      [ech_pkg::DATA_W-1:0] prdata,
    output logic                           pready
);
    import ech_pkg::*;

    t_ech_cfg   cfg;

    // input stage
    logic       r_in_valid;
    t_ech_in    r_in;
    // result stage
    logic       r_out_valid;
    t_ech_out   r_out;
    // controller state
    t_ech_state r_state;
    t_ech_state n_state;
    t_ech_out   n_out;

    logic       advance;   // item moves from input to result register

    ech_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ech_step u_step (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    // state advances exactly once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.engaged      <= 1'b0;
            r_state.auto_en      <= 1'b1;
            r_state.toggle_stamp <= '0;
            r_state.report_stamp <= '0;
            r_state.prev_ir      <= 1'b0;
            r_state.prev_btn     <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* rtl/ech_checker.sv */
// ----------------------------------------------------------------------------
// ech_checker
// Port-level checks on the engage controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ech_checker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      o_out_valid,
    input  wire logic                      i_out_ready,
    input  ech_pkg::t_ech_out              o_out_data
);
    import ech_pkg::*;

    logic [11:0] pulse_expect;
    assign pulse_expect = PULSE_BASE + 12'(o_out_data.angle_deg) * 12'd10;

    // indicators and engaged flag agree
    `ECH_ASSERT(a_leds, i_clk, i_rst_n, o_out_valid |-> (o_out_data.led_active == o_out_data.engaged_now) && (o_out_data.led_standby != o_out_data.engaged_now))

    // disengaged means parked servo; pulse always follows angle
    `ECH_ASSERT(a_servo, i_clk, i_rst_n, o_out_valid |-> (o_out_data.angle_deg <= ANGLE_MAX) && (o_out_data.servo_pulse_us == pulse_expect) && (o_out_data.engaged_now || (o_out_data.angle_deg == 8'd0)))

    // stalled result holds
    `ECH_ASSERT(a_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))

    // nothing is offered right after reset
    `ECH_ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind engage_controller_with_hysteresis_unit ech_checker u_ech_checker (.*);

`default_nettype wire
